### rtl/wctw_pkg.sv
// wctw_pkg: shared types and constants of the word cursor text window
// depends on nothing; used by the core, the checker and the bench
`default_nettype none

package wctw_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned LEN_W   = 9;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] COMMA_CHAR = 8'h2C;
  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 3'd0,
    CMD_FINISH  = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_ADVANCE = 3'd3,
    CMD_AHEAD   = 3'd4,
    CMD_BEHIND  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADV,
    ST_READ
  } state_e;

endpackage

`default_nettype wire

### rtl/wctw_win_addr.sv
// wctw_win_addr: store address and padding flag of one window position
// depends on nothing beyond its parameters
`default_nettype none

module wctw_win_addr #(
  parameter int unsigned ADDR_W = 9,
  parameter int unsigned KW     = 6
) (
  input  var logic [ADDR_W-1:0] cursor_i,
  input  var logic [ADDR_W-1:0] text_end_i,
  input  var logic [KW-1:0]     pos_i,
  input  var logic [KW-1:0]     width_i,
  input  var logic              behind_i,
  output logic [ADDR_W-1:0]     addr_o,
  output logic                  pad_o
);

  localparam int unsigned SUM_W = ADDR_W + KW;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] width_p1;
  logic [SUM_W-1:0] diff;

  assign sum      = SUM_W'(cursor_i) + SUM_W'(pos_i);
  assign width_p1 = SUM_W'(width_i) + SUM_W'(1);
  assign diff     = sum - width_p1;

  always_comb begin
    if (behind_i) begin
      pad_o  = sum < width_p1;
      addr_o = diff[ADDR_W-1:0];
    end else begin
      pad_o  = !(sum < SUM_W'(text_end_i));
      addr_o = sum[ADDR_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/word_cursor_text_window_core.sv
// word_cursor_text_window_core: text store with word cursor and read windows
// depends on wctw_pkg and wctw_win_addr
`default_nettype none

// Commands are taken when start_i is high and busy_o low; results come one per
// cycle on the result ports, marked by strobe_o, and cannot be held off. Load,
// clear and finish leave the core idle; finish returns its result beat the cycle
// after it is taken. Advance keeps the core busy while it scans stored
// characters, as the scan reads the text RAM one entry per cycle. Read-ahead and
// read-behind read the text RAM once per window position that is not padding,
// over the effective window width, and give a beat per position on consecutive cycles.
// The text RAM needs no clearing after reset.
module word_cursor_text_window_core #(
  parameter int unsigned STORE_CHARS = 511,
  parameter int unsigned MAX_WINDOW  = 32
) (
  input  var logic                         clk_i,
  input  var logic                         rst_ni,
  input  var logic                         start_i,
  output logic                             busy_o,
  input  var logic [wctw_pkg::CMD_W-1:0]   command_i,
  input  var logic [wctw_pkg::CHAR_W-1:0]  text_byte_i,
  input  var logic                         cfg_we_i,
  input  var logic [wctw_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                             strobe_o,
  output logic [wctw_pkg::CHAR_W-1:0]      text_char_o,
  output logic                             last_of_run_o,
  output logic [wctw_pkg::LEN_W-1:0]       text_length_o,
  output logic                             overflowed_o
);
  import wctw_pkg::*;

  localparam int unsigned DEPTH  = STORE_CHARS + 1;
  localparam int unsigned ADDR_W = $clog2(STORE_CHARS + 1);
  localparam int unsigned KW     = $clog2(MAX_WINDOW + 2);
  localparam logic [ADDR_W-1:0] STORE_MAX = ADDR_W'(STORE_CHARS);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] text_end_q, text_end_d;
  logic [ADDR_W-1:0] cursor_q, cursor_d;
  logic [ADDR_W-1:0] wr_pos_q, wr_pos_d;
  logic [ADDR_W-1:0] src_cnt_q, src_cnt_d;
  logic              ovf_q, ovf_d;
  logic [CFG_W-1:0]  width_q;
  logic [KW-1:0]     k_q, k_d;
  logic [ADDR_W-1:0] scan_q, scan_d;
  logic              first_q, first_d;
  logic              behind_q, behind_d;
  logic              pipe_vld_q, pipe_vld_d;
  logic              pipe_pad_q, pipe_pad_d;
  logic              pipe_last_q, pipe_last_d;

  logic              strobe_q, strobe_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_out_q, ovf_out_d;

  logic [CHAR_W-1:0] mem [DEPTH];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata, rdata_q;

  logic              accept;
  logic [KW-1:0]     w_eff, w_m1;
  logic [ADDR_W-1:0] win_addr;
  logic              win_pad;
  logic [ADDR_W-1:0] scan_next;
  logic              c_space, adv_hold, adv_end, adv_done, read_last;

  assign busy_o = (state_q != ST_IDLE) || pipe_vld_q;
  assign accept = start_i && !busy_o;

  always_comb begin
    if (width_q == '0) begin
      w_eff = KW'(1);
    end else if (int'(width_q) > int'(MAX_WINDOW)) begin
      w_eff = KW'(MAX_WINDOW);
    end else begin
      w_eff = KW'(width_q);
    end
  end
  assign w_m1      = w_eff - KW'(1);
  assign read_last = k_q == w_m1;

  assign scan_next = scan_q + ADDR_W'(1);
  assign c_space   = rdata_q == SPACE_CHAR;
  assign adv_hold  = first_q && c_space;
  assign adv_end   = scan_next == text_end_q;
  assign adv_done  = c_space || adv_end;

  wctw_win_addr #(
    .ADDR_W(ADDR_W),
    .KW    (KW)
  ) u_win_addr (
    .cursor_i  (cursor_q),
    .text_end_i(text_end_q),
    .pos_i     (k_q),
    .width_i   (w_eff),
    .behind_i  (behind_q),
    .addr_o    (win_addr),
    .pad_o     (win_pad)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(command_i))
            CMD_ADVANCE: begin
              if (cursor_q < text_end_q) state_d = ST_ADV;
            end
            CMD_AHEAD, CMD_BEHIND: state_d = ST_READ;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADV: begin
        if (adv_done) state_d = ST_IDLE;
      end
      ST_READ: begin
        if (read_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    text_end_d  = text_end_q;
    cursor_d    = cursor_q;
    wr_pos_d    = wr_pos_q;
    src_cnt_d   = src_cnt_q;
    ovf_d       = ovf_q;
    k_d         = k_q;
    scan_d      = scan_q;
    first_d     = first_q;
    behind_d    = behind_q;
    pipe_vld_d  = 1'b0;
    pipe_pad_d  = pipe_pad_q;
    pipe_last_d = pipe_last_q;
    strobe_d    = 1'b0;
    char_d      = char_q;
    last_d      = last_q;
    len_d       = len_q;
    ovf_out_d   = ovf_out_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_pos_q;
    mem_wdata   = text_byte_i;
    mem_re      = 1'b0;
    mem_raddr   = win_addr;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(command_i))
            CMD_LOAD, CMD_FINISH: begin
              if (cmd_e'(command_i) == CMD_FINISH || text_byte_i == NUL_CHAR) begin
                text_end_d = wr_pos_q;
                cursor_d   = '0;
                strobe_d   = 1'b1;
                char_d     = NUL_CHAR;
                last_d     = 1'b1;
                len_d      = LEN_W'(wr_pos_q);
                ovf_out_d  = ovf_q;
                wr_pos_d   = '0;
                src_cnt_d  = '0;
                ovf_d      = 1'b0;
              end else if (src_cnt_q >= STORE_MAX) begin
                ovf_d = 1'b1;
              end else begin
                src_cnt_d = src_cnt_q + ADDR_W'(1);
                if (text_byte_i != SPACE_CHAR) begin
                  mem_we    = 1'b1;
                  mem_wdata = (text_byte_i == COMMA_CHAR) ? SPACE_CHAR : text_byte_i;
                  wr_pos_d  = wr_pos_q + ADDR_W'(1);
                end
              end
            end
            CMD_CLEAR: text_end_d = '0;
            CMD_ADVANCE: begin
              if (cursor_q < text_end_q) begin
                mem_re    = 1'b1;
                mem_raddr = cursor_q;
                scan_d    = cursor_q;
                first_d   = 1'b1;
              end else if (cursor_q == text_end_q) begin
                cursor_d = '0;
              end
            end
            CMD_AHEAD: begin
              behind_d = 1'b0;
              k_d      = '0;
            end
            CMD_BEHIND: begin
              behind_d = 1'b1;
              k_d      = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ADV: begin
        first_d = 1'b0;
        if (adv_hold) begin
          cursor_d = cursor_q;
        end else if (adv_done) begin
          cursor_d = adv_end ? '0 : scan_next;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = scan_next;
          scan_d    = scan_next;
        end
      end
      ST_READ: begin
        mem_re      = !win_pad;
        mem_raddr   = win_addr;
        pipe_vld_d  = 1'b1;
        pipe_pad_d  = win_pad;
        pipe_last_d = read_last;
        k_d         = k_q + KW'(1);
      end
      default: ;
    endcase

    // window beat, in the cycle after its read
    if (pipe_vld_q) begin
      strobe_d  = 1'b1;
      char_d    = pipe_pad_q ? SPACE_CHAR : rdata_q;
      last_d    = pipe_last_q;
      len_d     = '0;
      ovf_out_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      text_end_q <= '0;
      cursor_q   <= '0;
      wr_pos_q   <= '0;
      src_cnt_q  <= '0;
      ovf_q      <= 1'b0;
      width_q    <= WIDTH_RESET;
      first_q    <= 1'b0;
      pipe_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      text_end_q <= text_end_d;
      cursor_q   <= cursor_d;
      wr_pos_q   <= wr_pos_d;
      src_cnt_q  <= src_cnt_d;
      ovf_q      <= ovf_d;
      if (cfg_we_i) width_q <= cfg_wdata_i;
      first_q    <= first_d;
      pipe_vld_q <= pipe_vld_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    scan_q      <= scan_d;
    behind_q    <= behind_d;
    pipe_pad_q  <= pipe_pad_d;
    pipe_last_q <= pipe_last_d;
    char_q      <= char_d;
    last_q      <= last_d;
    len_q       <= len_d;
    ovf_out_q   <= ovf_out_d;
  end

  assign strobe_o      = strobe_q;
  assign text_char_o   = char_q;
  assign last_of_run_o = last_q;
  assign text_length_o = len_q;
  assign overflowed_o  = ovf_out_q;

endmodule

`default_nettype wire

### rtl/wctw_checker.sv
// wctw_checker: port-level assertions for the word cursor text window core
// depends on wctw_pkg; bound to word_cursor_text_window_core
`default_nettype none

module wctw_checker (
  input var logic                         clk_i,
  input var logic                         rst_ni,
  input var logic                         start_i,
  input var logic                         busy_o,
  input var logic [wctw_pkg::CMD_W-1:0]   command_i,
  input var logic [wctw_pkg::CHAR_W-1:0]  text_byte_i,
  input var logic                         strobe_o,
  input var logic [wctw_pkg::CHAR_W-1:0]  text_char_o,
  input var logic                         last_of_run_o,
  input var logic [wctw_pkg::LEN_W-1:0]   text_length_o
);
  import wctw_pkg::*;

  logic accept;
  assign accept = start_i && !busy_o;

  // finish gives its commit beat right after it is taken
  a_finish_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i == CMD_FINISH |=> strobe_o && last_of_run_o && text_char_o == NUL_CHAR)
    else $error("finish without commit beat");

  // commands without results show no beat next cycle
  a_quiet_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (command_i == CMD_CLEAR || (command_i == CMD_LOAD && text_byte_i != NUL_CHAR))
    |=> !strobe_o)
    else $error("unexpected beat");

  // window beats are contiguous
  a_run_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_of_run_o |=> strobe_o)
    else $error("gap inside window run");

  // no new command while a run is still going out
  a_busy_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_of_run_o |-> busy_o)
    else $error("idle during window run");

  // a nonzero length only on a commit beat
  a_len_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && text_length_o != '0 |-> last_of_run_o)
    else $error("length outside commit beat");

endmodule

bind word_cursor_text_window_core wctw_checker u_wctw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .command_i    (command_i),
  .text_byte_i  (text_byte_i),
  .strobe_o     (strobe_o),
  .text_char_o  (text_char_o),
  .last_of_run_o(last_of_run_o),
  .text_length_o(text_length_o)
);

`default_nettype wire

### tb/sv/tb_word_cursor_text_window_core.sv
// tb_word_cursor_text_window_core: self-checking bench for the word cursor text window core
// drives commands and width writes, predicts every result beat and compares them in order
// depends on wctw_pkg and word_cursor_text_window_core
module tb_word_cursor_text_window_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wctw_pkg::*;

  localparam int unsigned STORE_CHARS = 511;
  localparam int unsigned MAX_WINDOW = 32;
  localparam int unsigned QUIET_CYCLES = STORE_CHARS + 40;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam logic [CMD_W-1:0] CMD_UNUSED6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED7 = 3'd7;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last_beat;
    logic [LEN_W-1:0]  len;
    logic              ovf;
  } beat_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] data;
    logic              pin;
    beat_t             pinned;
  } step_row_t;

  localparam beat_t NO_PIN = '0;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [CMD_W-1:0]  command_i;
  logic [CHAR_W-1:0] text_byte_i;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              strobe_o;
  logic [CHAR_W-1:0] text_char_o;
  logic              last_of_run_o;
  logic [LEN_W-1:0]  text_length_o;
  logic              overflowed_o;

  // predictor state
  logic [CHAR_W-1:0] text_mem [0:STORE_CHARS];
  int unsigned       committed_len = 0;
  int unsigned       cursor_pos = 0;
  int unsigned       fill_pos = 0;
  int unsigned       bytes_taken = 0;
  logic              dropped_flag = 1'b0;
  logic [CFG_W-1:0]  width_reg = WIDTH_RESET;

  beat_t       beats_due[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_pct = 0;
  int unsigned cycle_count = 0;
  step_row_t   dir_rows [0:24];

  word_cursor_text_window_core #(
    .STORE_CHARS(STORE_CHARS),
    .MAX_WINDOW (MAX_WINDOW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .text_byte_i  (text_byte_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .strobe_o     (strobe_o),
    .text_char_o  (text_char_o),
    .last_of_run_o(last_of_run_o),
    .text_length_o(text_length_o),
    .overflowed_o (overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still due", $time, beats_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin : beat_check
    beat_t want;
    if (rst_ni && strobe_o) begin
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual char %h last %b len %0d ovf %b",
                 $time, text_char_o, last_of_run_o, text_length_o, overflowed_o);
        mismatch_count++;
      end else begin
        want = beats_due.pop_front();
        if (text_char_o !== want.ch) begin
          $display("%0t: text_char expected %h actual %h", $time, want.ch, text_char_o);
          mismatch_count++;
        end
        if (last_of_run_o !== want.last_beat) begin
          $display("%0t: last_of_run expected %b actual %b", $time, want.last_beat,
                   last_of_run_o);
          mismatch_count++;
        end
        if (text_length_o !== want.len) begin
          $display("%0t: text_length expected %0d actual %0d", $time, want.len,
                   text_length_o);
          mismatch_count++;
        end
        if (overflowed_o !== want.ovf) begin
          $display("%0t: overflowed expected %b actual %b", $time, want.ovf, overflowed_o);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int unsigned window_chars();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WINDOW) return MAX_WINDOW;
    return width_reg;
  endfunction

  task automatic commit_text();
    beat_t b;
    committed_len = fill_pos;
    cursor_pos = 0;
    b.ch = NUL_CHAR;
    b.last_beat = 1'b1;
    b.len = committed_len[LEN_W-1:0];
    b.ovf = dropped_flag;
    beats_due.push_back(b);
    fill_pos = 0;
    bytes_taken = 0;
    dropped_flag = 1'b0;
  endtask

  task automatic predict_text_window(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] data);
    int unsigned w, k, i, back;
    bit          hit;
    beat_t       b;
    case (cmd)
      CMD_LOAD: begin
        if (data == NUL_CHAR) begin
          commit_text();
        end else if (bytes_taken >= STORE_CHARS) begin
          dropped_flag = 1'b1;
        end else begin
          bytes_taken++;
          if (data != SPACE_CHAR && fill_pos <= STORE_CHARS) begin
            text_mem[fill_pos] = (data == COMMA_CHAR) ? SPACE_CHAR : data;
            fill_pos++;
          end
        end
      end
      CMD_FINISH: commit_text();
      CMD_CLEAR: committed_len = 0;
      CMD_ADVANCE: begin
        i = cursor_pos;
        if (i < committed_len && text_mem[i] != SPACE_CHAR) begin
          hit = 1'b0;
          while (i < committed_len && !hit) begin
            hit = (text_mem[i] == SPACE_CHAR);
            i++;
          end
        end
        if (i == committed_len) i = 0;
        cursor_pos = i;
      end
      CMD_AHEAD, CMD_BEHIND: begin
        w = window_chars();
        for (k = 0; k < w; k++) begin
          b = '0;
          b.ch = SPACE_CHAR;
          b.last_beat = (k + 1 == w);
          if (cmd == CMD_AHEAD) begin
            if (cursor_pos + k < committed_len) b.ch = text_mem[cursor_pos + k];
          end else begin
            back = w - 1 - k;
            if (cursor_pos >= 2 && back <= cursor_pos - 2)
              b.ch = text_mem[cursor_pos - 2 - back];
          end
          beats_due.push_back(b);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] data,
                          input logic pin, input beat_t pinned);
    int unsigned first, j;
    beat_t       b;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    command_i <= cmd;
    text_byte_i <= data;
    do @(posedge clk_i); while (busy_o);
    first = beats_due.size();
    predict_text_window(cmd, data);
    if (pin) begin
      for (j = first; j < beats_due.size(); j++) begin
        b = beats_due[j];
        b.ch = pinned.ch;
        b.len = pinned.len;
        b.ovf = pinned.ovf;
        beats_due[j] = b;
      end
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (beats_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] value);
    drain_results();
    repeat (QUIET_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_reg = value;
  endtask

  function automatic logic [CHAR_W-1:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 11) return 8'h61 + CHAR_W'($urandom_range(0, 25));
    if (r < 15) return COMMA_CHAR;
    if (r < 18) return SPACE_CHAR;
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  function automatic logic [CMD_W-1:0] pick_cursor_op();
    int unsigned r;
    r = $urandom_range(0, 2);
    if (r == 0) return CMD_ADVANCE;
    if (r == 1) return CMD_AHEAD;
    return CMD_BEHIND;
  endfunction

  task automatic random_phase(input int unsigned n_items, input int unsigned idle_in);
    int unsigned sent, len, j, kind, tail;
    logic [CMD_W-1:0] cmd;
    idle_pct = idle_in;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
        for (j = 0; j < len; j++) send_cmd(CMD_LOAD, pick_text_byte(), 1'b0, NO_PIN);
        if ($urandom_range(0, 1) == 0)
          send_cmd(CMD_FINISH, CHAR_W'($urandom_range(0, 255)), 1'b0, NO_PIN);
        else
          send_cmd(CMD_LOAD, NUL_CHAR, 1'b0, NO_PIN);
        tail = $urandom_range(1, 6);
        for (j = 0; j < tail; j++)
          send_cmd(pick_cursor_op(), CHAR_W'($urandom_range(0, 255)), 1'b0, NO_PIN);
        sent += len + 1 + tail;
      end else if (kind <= 8) begin
        cmd = CMD_W'($urandom_range(0, 7));
        send_cmd(cmd, CHAR_W'($urandom_range(0, 255)), 1'b0, NO_PIN);
        if (cmd <= CMD_BEHIND) sent++;
      end else begin
        send_cmd(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)), 1'b0, NO_PIN);
        tail = $urandom_range(1, 3);
        for (j = 0; j < tail; j++)
          send_cmd(pick_cursor_op(), CHAR_W'($urandom_range(0, 255)), 1'b0, NO_PIN);
        sent += 1 + tail;
      end
      if ($urandom_range(0, 24) == 0) drain_results();
    end
  endtask

  initial begin
    int unsigned j;
    logic [CHAR_W-1:0] b;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    command_i <= CMD_LOAD;
    text_byte_i <= NUL_CHAR;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;

    dir_rows[0]  = {CMD_BEHIND,  8'h00, 1'b1, SPACE_CHAR, 1'b0, 9'd0, 1'b0};
    dir_rows[1]  = {CMD_AHEAD,   8'hA5, 1'b1, SPACE_CHAR, 1'b0, 9'd0, 1'b0};
    dir_rows[2]  = {CMD_FINISH,  8'hFF, 1'b1, NUL_CHAR, 1'b0, 9'd0, 1'b0};
    dir_rows[3]  = {CMD_UNUSED6, 8'hFF, 1'b0, NO_PIN};
    dir_rows[4]  = {CMD_UNUSED7, 8'h00, 1'b0, NO_PIN};
    dir_rows[5]  = {CMD_LOAD,    8'h68, 1'b0, NO_PIN};
    dir_rows[6]  = {CMD_LOAD,    COMMA_CHAR, 1'b0, NO_PIN};
    dir_rows[7]  = {CMD_LOAD,    SPACE_CHAR, 1'b0, NO_PIN};
    dir_rows[8]  = {CMD_LOAD,    8'hFF, 1'b0, NO_PIN};
    dir_rows[9]  = {CMD_LOAD,    8'h80, 1'b0, NO_PIN};
    dir_rows[10] = {CMD_LOAD,    COMMA_CHAR, 1'b0, NO_PIN};
    dir_rows[11] = {CMD_LOAD,    8'h01, 1'b0, NO_PIN};
    dir_rows[12] = {CMD_LOAD,    NUL_CHAR, 1'b1, NUL_CHAR, 1'b0, 9'd6, 1'b0};
    dir_rows[13] = {CMD_AHEAD,   8'h00, 1'b0, NO_PIN};
    dir_rows[14] = {CMD_ADVANCE, 8'h00, 1'b0, NO_PIN};
    dir_rows[15] = {CMD_BEHIND,  8'h00, 1'b0, NO_PIN};
    dir_rows[16] = {CMD_ADVANCE, 8'hFF, 1'b0, NO_PIN};
    dir_rows[17] = {CMD_AHEAD,   8'h00, 1'b0, NO_PIN};
    dir_rows[18] = {CMD_ADVANCE, 8'h00, 1'b0, NO_PIN};
    dir_rows[19] = {CMD_ADVANCE, 8'h00, 1'b0, NO_PIN};
    dir_rows[20] = {CMD_CLEAR,   8'h7F, 1'b0, NO_PIN};
    dir_rows[21] = {CMD_AHEAD,   8'h00, 1'b1, SPACE_CHAR, 1'b0, 9'd0, 1'b0};
    dir_rows[22] = {CMD_BEHIND,  8'h00, 1'b0, NO_PIN};
    dir_rows[23] = {CMD_ADVANCE, 8'h00, 1'b0, NO_PIN};
    dir_rows[24] = {CMD_BEHIND,  8'h00, 1'b0, NO_PIN};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 25;
    for (j = 0; j < 25; j++)
      send_cmd(dir_rows[j].cmd, dir_rows[j].data, dir_rows[j].pin, dir_rows[j].pinned);

    // full store, then bytes past the limit
    write_width(6'd63);
    idle_pct = 20;
    for (j = 0; j < STORE_CHARS; j++) begin
      b = CHAR_W'($urandom_range(1, 255));
      if (b == SPACE_CHAR) b = COMMA_CHAR;
      send_cmd(CMD_LOAD, b, 1'b0, NO_PIN);
    end
    for (j = 0; j < 4; j++) send_cmd(CMD_LOAD, CHAR_W'($urandom_range(1, 255)), 1'b0, NO_PIN);
    send_cmd(CMD_FINISH, 8'h00, 1'b1, {NUL_CHAR, 1'b1, 9'd511, 1'b1});
    send_cmd(CMD_AHEAD, 8'h00, 1'b0, NO_PIN);
    for (j = 0; j < 3; j++) send_cmd(CMD_ADVANCE, 8'h00, 1'b0, NO_PIN);
    send_cmd(CMD_BEHIND, 8'h00, 1'b0, NO_PIN);
    send_cmd(CMD_AHEAD, 8'h00, 1'b0, NO_PIN);

    write_width(6'd0);
    random_phase(32, 30);
    write_width(6'd32);
    random_phase(32, 0);
    write_width(6'd1);
    random_phase(32, 50);
    write_width(CFG_W'($urandom_range(2, 31)));
    random_phase(32, 30);
    write_width(CFG_W'($urandom_range(1, 32)));
    random_phase(32, 0);

    drain_results();
    repeat (80) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/wctw_pkg.sv
rtl/wctw_win_addr.sv
rtl/word_cursor_text_window_core.sv
rtl/wctw_checker.sv
tb/sv/tb_word_cursor_text_window_core.sv
